/* rtl/eets_pkg.sv */
// shared types and constants for the edge event to series table
package eets_pkg;

    localparam int MAX_EDGES = 256;
    localparam int NODE_BITS = 16;
    localparam int MAX_SLOTS = 1024;
    localparam int ROW_WORDS = (MAX_SLOTS + 63) / 64;
    localparam int EDGE_W    = $clog2(MAX_EDGES);
    localparam int CNT_W     = $clog2(MAX_EDGES + 1);
    localparam int WORD_W    = $clog2(ROW_WORDS);
    localparam int KEY_W     = 2 * NODE_BITS;
    localparam int BIT_ADDR_W = EDGE_W + WORD_W;
    localparam int BIT_DEPTH = MAX_EDGES * ROW_WORDS;

    localparam logic       OP_RECORD = 1'b0;
    localparam logic       OP_READ   = 1'b1;
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    typedef struct packed {
        logic        op;
        logic [15:0] node_a;
        logic [15:0] node_b;
        logic [9:0]  time_stamp;
        logic [7:0]  read_row;
        logic [3:0]  read_word;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  edge_id;
        logic        is_new;
        logic [1:0]  status;
        logic [63:0] read_data;
    } out_word_t;

endpackage

/* rtl/edge_event_to_series_table.sv */
// top level of the edge event to series table
// Records time-stamped edge events into a per-edge presence bitmap and reads
// bitmap words back. After reset a clearing pass (one bitmap word a cycle)
// zeroes all 4096 bitmap words before the first word is accepted. A read
// registers the bitmap word and then captures it into the output word. A record
// event searches the pair key memory one entry at a time (one read, one
// compare per entry), then does the read-modify-write of one bitmap word. An
// out-of-range time is answered without a search. One word is worked on at a time.
module edge_event_to_series_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  eets_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output eets_pkg::out_word_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [10:0]          cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_RMW_RD, S_RMW_WR, S_READ, S_OUT}
        state_t;

    state_t                            state_reg;
    eets_pkg::in_word_t                in_reg;
    logic [10:0]                       time_slots_reg;
    eets_pkg::out_word_t               out_reg;
    logic                              mem_ok;
    logic                              srch_start;
    logic                              srch_done;
    logic                              srch_hit;
    logic                              srch_full;
    logic [eets_pkg::EDGE_W-1:0]       srch_index;
    logic [eets_pkg::EDGE_W-1:0]       edge_reg;
    logic                              rd_en;
    logic [eets_pkg::BIT_ADDR_W-1:0]   rd_addr;
    logic [63:0]                       rd_data;
    logic                              wr_en;
    logic [eets_pkg::BIT_ADDR_W-1:0]   wr_addr;
    logic                              read_in_range;
    logic                              accept;
    logic                              time_bad;

    assign cfg_ready = 1'b1;
    assign in_ready  = state_reg == S_IDLE && mem_ok;
    assign accept    = in_valid && in_ready;
    assign out_valid = state_reg == S_OUT;
    assign out_data  = out_reg;

    assign time_bad = {1'b0, in_data.time_stamp} >= time_slots_reg
        || 32'(in_data.time_stamp) >= 32'(eets_pkg::MAX_SLOTS);
    assign srch_start = accept && in_data.op == eets_pkg::OP_RECORD && !time_bad;

    assign read_in_range = 32'(in_data.read_row) < 32'(eets_pkg::MAX_EDGES)
        && 32'(in_data.read_word) < 32'(eets_pkg::ROW_WORDS);

    assign wr_addr = {edge_reg, in_reg.time_stamp[9:6]};
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_en   = accept && in_data.op == eets_pkg::OP_READ;
            rd_addr = {in_data.read_row[eets_pkg::EDGE_W-1:0],
                       in_data.read_word[eets_pkg::WORD_W-1:0]};
        end
        else
        begin
            rd_en   = state_reg == S_RMW_RD;
            rd_addr = wr_addr;
        end
    end
    assign wr_en = state_reg == S_RMW_WR;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_slots_reg <= 11'd1024;
        end
        else if (cfg_valid)
        begin
            time_slots_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        in_reg <= in_data;
                        if (in_data.op == eets_pkg::OP_READ)
                        begin
                            out_reg   <= '0;
                            state_reg <= read_in_range ? S_READ : S_OUT;
                        end
                        else if (time_bad)
                        begin
                            out_reg   <= eets_pkg::out_word_t'({8'd0, 1'b0,
                                             eets_pkg::ST_RANGE, 64'd0});
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            out_reg   <= '0;
                            state_reg <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (srch_done)
                    begin
                        if (srch_full)
                        begin
                            out_reg.status <= eets_pkg::ST_FULL;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            edge_reg        <= srch_index;
                            out_reg.edge_id <= 8'(srch_index);
                            out_reg.is_new  <= ~srch_hit;
                            state_reg       <= S_RMW_RD;
                        end
                    end
                end
                S_RMW_RD:
                begin
                    state_reg <= S_RMW_WR;
                end
                S_RMW_WR:
                begin
                    state_reg <= S_OUT;
                end
                S_READ:
                begin
                    out_reg.read_data <= rd_data;
                    state_reg         <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    eets_key_search u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .start (srch_start),
        .key   ({in_data.node_a[eets_pkg::NODE_BITS-1:0],
                 in_data.node_b[eets_pkg::NODE_BITS-1:0]}),
        .done  (srch_done),
        .hit   (srch_hit),
        .full  (srch_full),
        .index (srch_index)
    );

    eets_bitmap u_bitmap (
        .clk          (clk),
        .rst_n        (rst_n),
        .ready_busy_n (mem_ok),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (rd_data | (64'd1 << in_reg.time_stamp[5:0]))
    );

endmodule

/* rtl/eets_key_search.sv */
// sequential pair key search with allocation of new keys
module eets_key_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [eets_pkg::KEY_W-1:0]  key,
    output logic                        done,
    output logic                        hit,
    output logic                        full,
    output logic [eets_pkg::EDGE_W-1:0] index
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP} state_t;

    logic [eets_pkg::KEY_W-1:0] key_mem [eets_pkg::MAX_EDGES];
    logic [eets_pkg::KEY_W-1:0] rd_key_reg;
    logic [eets_pkg::CNT_W-1:0] count_reg;
    logic [eets_pkg::CNT_W-1:0] ptr_reg;
    logic [eets_pkg::KEY_W-1:0] key_reg;
    logic                       wr_en;
    state_t                     state_reg;

    assign wr_en = state_reg == S_READ && ptr_reg == count_reg
        && count_reg != eets_pkg::CNT_W'(eets_pkg::MAX_EDGES);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[ptr_reg[eets_pkg::EDGE_W-1:0]] <= key_reg;
        end
        rd_key_reg <= key_mem[ptr_reg[eets_pkg::EDGE_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            done      <= 1'b0;
            hit       <= 1'b0;
            full      <= 1'b0;
            index     <= '0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        key_reg   <= key;
                        ptr_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // end of stored keys: allocate or report full
                    if (ptr_reg == count_reg)
                    begin
                        done      <= 1'b1;
                        hit       <= 1'b0;
                        index     <= ptr_reg[eets_pkg::EDGE_W-1:0];
                        full      <= ~wr_en;
                        if (wr_en)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (rd_key_reg == key_reg)
                    begin
                        done      <= 1'b1;
                        hit       <= 1'b1;
                        full      <= 1'b0;
                        index     <= ptr_reg[eets_pkg::EDGE_W-1:0];
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/eets_bitmap.sv */
// presence bitmap memory with clearing pass and read-modify-write
module eets_bitmap (
    input  logic                            clk,
    input  logic                            rst_n,
    output logic                            ready_busy_n,
    input  logic                            rd_en,
    input  logic [eets_pkg::BIT_ADDR_W-1:0] rd_addr,
    output logic [63:0]                     rd_data,
    input  logic                            wr_en,
    input  logic [eets_pkg::BIT_ADDR_W-1:0] wr_addr,
    input  logic [63:0]                     wr_data
);

    logic [63:0]                     mem [eets_pkg::BIT_DEPTH];
    logic [eets_pkg::BIT_ADDR_W:0]   clr_reg;
    logic                            clearing;

    assign clearing     = ~clr_reg[eets_pkg::BIT_ADDR_W];
    assign ready_busy_n = ~clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_reg[eets_pkg::BIT_ADDR_W-1:0]] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
